// File: src/wkcr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wkcr_pkg: shared types and constants
// Opcodes, sizes and MD5 tables for the key challenge-response block.
// ----------------------------------------------------------------------------
package wkcr_pkg;

  localparam int MaxKeyChars    = 256;
  localparam int CountW         = $clog2(MaxKeyChars + 1);
  localparam int ChallengeBytes = 8;
  localparam int ChalIdxW       = $clog2(ChallengeBytes);
  localparam int ChalCntW       = $clog2(ChallengeBytes + 1);

  localparam logic [1:0] OpKey1 = 2'd0;
  localparam logic [1:0] OpKey2 = 2'd1;
  localparam logic [1:0] OpChal = 2'd2;

  localparam logic [1:0] StOk      = 2'd0;
  localparam logic [1:0] StNoSpc1  = 2'd1;
  localparam logic [1:0] StNoSpc2  = 2'd2;

  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;

  // Job handed from the front end to the back end.
  typedef struct packed {
    logic [31:0]       key1;
    logic [31:0]       key2;
    logic [CountW-1:0] spc1;
    logic [CountW-1:0] spc2;
    logic [63:0]       chal;
  } job_t;

  function automatic logic [31:0] md5_k(input logic [5:0] i);
    logic [31:0] k [64];
    k = '{
      32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
      32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
      32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
      32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
      32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
      32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
      32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
      32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
      32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
      32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
      32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
      32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
      32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
      32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
      32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
      32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391};
    return k[i];
  endfunction

  function automatic logic [4:0] md5_s(input logic [5:0] i);
    logic [4:0] s [16];
    s = '{5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
          5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21};
    return s[{i[5:4], i[1:0]}];
  endfunction

endpackage

// File: src/websocket_key_challenge_response.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// websocket_key_challenge_response: key challenge-response engine
// Parses two keys and eight challenge bytes and emits the MD5 response.
// ----------------------------------------------------------------------------
// Usage: drive opcode_i and data_byte_i with start; a beat is taken on a
// clock edge with start high and busy low. The eighth challenge byte hands
// a job to the back end, which holds busy high while it works: the hand-off,
// bit-serial division (both keys in parallel), MD5 rounds (one round per
// cycle through a single round unit), then 16 result beats on consecutive
// cycles. A key with no spaces gives one error beat instead, after the
// hand-off.
// Results are shown for one cycle with strobe; the receiver cannot stall.
// Reset clears the key parsers, the challenge count and the sequencer.
// ----------------------------------------------------------------------------
module websocket_key_challenge_response import wkcr_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  output logic       busy,
  input  logic [1:0] opcode_i,
  input  logic [7:0] data_byte_i,
  output logic       strobe,
  output logic [7:0] digest_byte_o,
  output logic [3:0] byte_index_o,
  output logic [1:0] status_o,
  output logic       last_o
);

  logic job_valid;
  job_t job;

  wkcr_front u_front (
    .clk_i, .rst_ni,
    .take_i      (start && !busy),
    .opcode_i, .data_byte_i,
    .job_valid_o (job_valid),
    .job_o       (job)
  );

  wkcr_back u_back (
    .clk_i, .rst_ni,
    .job_valid_i (job_valid),
    .job_i       (job),
    .busy_o      (busy),
    .strobe_o    (strobe),
    .digest_byte_o, .byte_index_o, .status_o, .last_o
  );

  // An error beat is always the last one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe && status_o != StOk |-> last_o)
    else $error("error beat without last");

  // A handed-off job makes the block busy.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_valid |-> busy)
    else $error("job accepted while not busy");

  // A last digest beat carries the final index.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe && last_o && status_o == StOk |-> byte_index_o == 4'd15)
    else $error("last beat at wrong index");

endmodule

// File: src/wkcr_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wkcr_front: key parser and challenge collector
// Builds key values and space counts and packs a job on the last challenge.
// ----------------------------------------------------------------------------
module wkcr_front import wkcr_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       take_i,
  input  logic [1:0] opcode_i,
  input  logic [7:0] data_byte_i,
  output logic       job_valid_o,
  output job_t       job_o
);

  logic [31:0]       acc_q [2];
  logic [31:0]       acc_d [2];
  logic [CountW-1:0] spc_q [2];
  logic [CountW-1:0] spc_d [2];
  logic [CountW-1:0] pend_q [2];
  logic [CountW-1:0] pend_d [2];
  logic [1:0]        started_q, started_d;
  logic [63:0]       chal_q, chal_d;
  logic [ChalCntW-1:0] cnt_q, cnt_d;
  logic              done;

  function automatic logic [CountW-1:0] sat(input logic [CountW:0] s);
    return (s > (CountW+1)'(MaxKeyChars)) ? CountW'(MaxKeyChars) : s[CountW-1:0];
  endfunction

  // Next state of both key parsers and the challenge buffer.
  always_comb begin
    acc_d = acc_q; spc_d = spc_q; pend_d = pend_q;
    started_d = started_q; chal_d = chal_q; cnt_d = cnt_q;
    done = 1'b0;
    if (take_i) begin
      if (opcode_i == OpKey1 || opcode_i == OpKey2) begin
        if (data_byte_i == ChSpace) begin
          if (started_q[opcode_i[0]]) begin
            pend_d[opcode_i[0]] = sat({1'b0, pend_q[opcode_i[0]]} + 1'b1);
          end
        end else begin
          started_d[opcode_i[0]] = 1'b1;
          spc_d[opcode_i[0]] = sat({1'b0, spc_q[opcode_i[0]]} +
                                   {1'b0, pend_q[opcode_i[0]]});
          pend_d[opcode_i[0]] = '0;
          if (data_byte_i >= ChZero && data_byte_i <= ChNine) begin
            acc_d[opcode_i[0]] = (acc_q[opcode_i[0]] << 3) + (acc_q[opcode_i[0]] << 1)
                                 + {28'd0, data_byte_i[3:0]};
          end
        end
      end else if (opcode_i == OpChal) begin
        chal_d[8*(ChallengeBytes-1-cnt_q[ChalIdxW-1:0]) +: 8] = data_byte_i;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == ChalCntW'(ChallengeBytes - 1)) begin
          done = 1'b1;
          acc_d = '{default: '0}; spc_d = '{default: '0};
          pend_d = '{default: '0}; started_d = '0; cnt_d = '0;
        end
      end
    end
  end

  // Parser state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '{default: '0}; spc_q <= '{default: '0};
      pend_q <= '{default: '0}; started_q <= '0; cnt_q <= '0;
      job_valid_o <= 1'b0;
    end else begin
      acc_q <= acc_d; spc_q <= spc_d; pend_q <= pend_d;
      started_q <= started_d; cnt_q <= cnt_d;
      job_valid_o <= done;
    end
  end

  // Challenge bytes and the job payload.
  always_ff @(posedge clk_i) begin
    chal_q <= chal_d;
    if (done) begin
      job_o.key1 <= acc_q[0];
      job_o.key2 <= acc_q[1];
      job_o.spc1 <= spc_q[0];
      job_o.spc2 <= spc_q[1];
      job_o.chal <= {chal_q[63:8], data_byte_i};
    end
  end

endmodule

// File: src/wkcr_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wkcr_back: divider, MD5 core and result sequencer
// Divides both keys bit serially, runs 64 MD5 rounds and emits the digest.
// ----------------------------------------------------------------------------
module wkcr_back import wkcr_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       job_valid_i,
  input  job_t       job_i,
  output logic       busy_o,
  output logic       strobe_o,
  output logic [7:0] digest_byte_o,
  output logic [3:0] byte_index_o,
  output logic [1:0] status_o,
  output logic       last_o
);

  typedef enum logic [4:0] {
    SIdle = 5'b00001,
    SDiv  = 5'b00010,
    SMd5  = 5'b00100,
    SOut  = 5'b01000,
    SErr  = 5'b10000
  } state_e;

  state_e      state_q, state_d;
  logic [5:0]  step_q, step_d;
  logic [31:0] q1_q, q1_d, q2_q, q2_d;
  logic [CountW-1:0] r1_q, r1_d, r2_q, r2_d, d1_q, d2_q;
  logic [63:0] chal_q;
  logic [31:0] a_q, a_d, b_q, b_d, c_q, c_d, d_q, d_d;
  logic [1:0]  err_q;
  logic [31:0] m [16];
  logic [31:0] f, t, rot;
  logic [3:0]  g;
  logic [5:0]  r;
  logic [127:0] dig;
  logic [CountW:0] t1, t2;

  // Message words, little-endian from the big-endian byte stream.
  always_comb begin
    m = '{default: 32'd0};
    m[0] = {q1_q[7:0], q1_q[15:8], q1_q[23:16], q1_q[31:24]};
    m[1] = {q2_q[7:0], q2_q[15:8], q2_q[23:16], q2_q[31:24]};
    m[2] = {chal_q[39:32], chal_q[47:40], chal_q[55:48], chal_q[63:56]};
    m[3] = {chal_q[7:0], chal_q[15:8], chal_q[23:16], chal_q[31:24]};
    m[4] = 32'h0000_0080;
    m[14] = 32'h0000_0080;
  end

  // One MD5 round.
  always_comb begin
    r = step_q;
    case (r[5:4])
      2'd0: begin f = (b_q & c_q) | (~b_q & d_q); g = r[3:0]; end
      2'd1: begin f = (d_q & b_q) | (~d_q & c_q); g = 4'(5 * r[3:0] + 1); end
      2'd2: begin f = b_q ^ c_q ^ d_q; g = 4'(3 * r[3:0] + 5); end
      default: begin f = c_q ^ (b_q | ~d_q); g = 4'(7 * r[3:0]); end
    endcase
    t = f + a_q + md5_k(r) + m[g];
    rot = (t << md5_s(r)) | (t >> (6'd32 - {1'b0, md5_s(r)}));
  end

  assign t1 = {r1_q, q1_q[31]} - {1'b0, d1_q};
  assign t2 = {r2_q, q2_q[31]} - {1'b0, d2_q};
  assign dig = {d_q + 32'h10325476, c_q + 32'h98badcfe,
                b_q + 32'hefcdab89, a_q + 32'h67452301};

  // Sequencer.
  always_comb begin
    state_d = state_q; step_d = step_q;
    q1_d = q1_q; q2_d = q2_q; r1_d = r1_q; r2_d = r2_q;
    a_d = a_q; b_d = b_q; c_d = c_q; d_d = d_q;
    case (state_q)
      SIdle: begin
        if (job_valid_i) begin
          step_d = '0;
          q1_d = job_i.key1; q2_d = job_i.key2; r1_d = '0; r2_d = '0;
          state_d = (job_i.spc1 == '0 || job_i.spc2 == '0) ? SErr : SDiv;
        end
      end
      SDiv: begin
        // Restoring division, one quotient bit per cycle for both keys.
        if (!t1[CountW]) begin
          r1_d = t1[CountW-1:0]; q1_d = {q1_q[30:0], 1'b1};
        end else begin
          r1_d = {r1_q[CountW-2:0], q1_q[31]}; q1_d = {q1_q[30:0], 1'b0};
        end
        if (!t2[CountW]) begin
          r2_d = t2[CountW-1:0]; q2_d = {q2_q[30:0], 1'b1};
        end else begin
          r2_d = {r2_q[CountW-2:0], q2_q[31]}; q2_d = {q2_q[30:0], 1'b0};
        end
        step_d = step_q + 1'b1;
        if (step_q == 6'd31) begin
          step_d = '0; state_d = SMd5;
          a_d = 32'h67452301; b_d = 32'hefcdab89;
          c_d = 32'h98badcfe; d_d = 32'h10325476;
        end
      end
      SMd5: begin
        a_d = d_q; d_d = c_q; c_d = b_q; b_d = b_q + rot;
        step_d = step_q + 1'b1;
        if (step_q == 6'd63) begin
          step_d = '0; state_d = SOut;
        end
      end
      SOut: begin
        step_d = step_q + 1'b1;
        if (step_q == 6'd15) begin
          step_d = '0; state_d = SIdle;
        end
      end
      SErr: state_d = SIdle;
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    q1_q <= q1_d; q2_q <= q2_d; r1_q <= r1_d; r2_q <= r2_d;
    a_q <= a_d; b_q <= b_d; c_q <= c_d; d_q <= d_d;
    if (state_q == SIdle && job_valid_i) begin
      d1_q <= job_i.spc1; d2_q <= job_i.spc2; chal_q <= job_i.chal;
      err_q <= (job_i.spc1 == '0) ? StNoSpc1 : StNoSpc2;
    end
  end

  assign busy_o        = (state_q != SIdle) || job_valid_i;
  assign strobe_o      = (state_q == SOut) || (state_q == SErr);
  assign digest_byte_o = (state_q == SOut) ? dig[8*step_q[3:0] +: 8] : 8'd0;
  assign byte_index_o  = (state_q == SOut) ? step_q[3:0] : 4'd0;
  assign status_o      = (state_q == SErr) ? err_q : StOk;
  assign last_o        = (state_q == SErr) || (state_q == SOut && step_q == 6'd15);

endmodule
